// ===== rtl/idaf_pkg.sv =====
// ----------------------------------------------------------------------------
// idaf_pkg
// shared constants, types and state encoding for the factorial register device
// ----------------------------------------------------------------------------
package idaf_pkg;

   localparam int AddrBits = 8;
   localparam int DataBits = 32;
   localparam int CountBits = 6;

   localparam logic [AddrBits-1:0] OffIdent  = AddrBits'('h00);
   localparam logic [AddrBits-1:0] OffLive   = AddrBits'('h04);
   localparam logic [AddrBits-1:0] OffFact   = AddrBits'('h08);
   localparam logic [AddrBits-1:0] OffStatus = AddrBits'('h20);

   localparam logic [7:0]  IdentMagic   = 8'hED;
   localparam logic [15:0] IdentVersion = 16'h0100;
   localparam logic [DataBits-1:0] IdentWord = {IdentVersion, 8'h00, IdentMagic};

   // busy never shows to an access, so status always reads idle
   localparam logic [DataBits-1:0] StatusIdle = '0;

   localparam logic [DataBits-1:0] FactZeroFrom = DataBits'(34);
   localparam logic [DataBits-1:0] FactFirstLoop = DataBits'(2);

   typedef enum logic { OpRead = 1'b0, OpWrite = 1'b1 } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_RUN  = 2'd2
   } state_type;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic fact_loop;
      logic last_step;
   } status_type;

endpackage

// ===== rtl/idaf_ctrl.sv =====
// ----------------------------------------------------------------------------
// idaf_ctrl
// sequencer: takes a request, runs the factorial loop, fires the response strobe
// ----------------------------------------------------------------------------
module idaf_ctrl import idaf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   output logic       rsp_strobe,
   output cmd_type    cmd,
   input  status_type sts
);

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (sts.fact_loop) state_in = ST_RUN;
            else state_in = ST_IDLE;
         end
         ST_RUN: begin
            if (sts.last_step) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      strobe_in = 1'b0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.load_req = start;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            strobe_in = !sts.fact_loop;
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            strobe_in = sts.last_step;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe = strobe_ff;

endmodule

// ===== rtl/idaf_dp.sv =====
// ----------------------------------------------------------------------------
// idaf_dp
// datapath: request latch, register file, factorial multiplier, response register
// ----------------------------------------------------------------------------
module idaf_dp import idaf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          sts,
   input  logic                req_operation,
   input  logic [AddrBits-1:0] req_address,
   input  logic [DataBits-1:0] req_write_data,
   output logic [DataBits-1:0] rsp_read_data
);

   op_type               op_ff;
   logic [AddrBits-1:0]  addr_ff;
   logic [DataBits-1:0]  data_ff;
   logic [DataBits-1:0]  live_ff, live_in;
   logic [DataBits-1:0]  fact_ff, fact_in;
   logic [DataBits-1:0]  acc_ff, acc_in;
   logic [CountBits-1:0] k_ff, k_in;
   logic [DataBits-1:0]  rsp_ff, rsp_in;
   logic [DataBits-1:0]  product;
   logic [DataBits-1:0]  read_word;
   logic                 fact_write;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff   <= op_type'(req_operation);
         addr_ff <= req_address;
         data_ff <= req_write_data;
      end
   end

   assign fact_write = (op_ff == OpWrite) && (addr_ff == OffFact);
   assign sts.fact_loop = fact_write && (data_ff >= FactFirstLoop) && (data_ff < FactZeroFrom);
   assign sts.last_step = (k_ff == data_ff[CountBits-1:0]);

   // low word of acc * k
   assign product = DataBits'(acc_ff * DataBits'(k_ff));

   always_comb begin
      case (addr_ff)
         OffIdent:  read_word = IdentWord;
         OffLive:   read_word = ~live_ff;
         OffFact:   read_word = fact_ff;
         OffStatus: read_word = StatusIdle;
         default:   read_word = '0;
      endcase
   end

   always_comb begin
      live_in = live_ff;
      fact_in = fact_ff;
      acc_in  = acc_ff;
      k_in    = k_ff;
      rsp_in  = rsp_ff;
      if (cmd.exec) begin
         rsp_in = (op_ff == OpWrite) ? '0 : read_word;
         acc_in = DataBits'(1);
         k_in   = CountBits'(2);
         if (op_ff == OpWrite && addr_ff == OffLive) live_in = data_ff;
         if (fact_write && !sts.fact_loop) begin
            // zero or one gives 1, big arguments wrap to 0
            fact_in = (data_ff < FactFirstLoop) ? DataBits'(1) : '0;
         end
      end
      if (cmd.step) begin
         acc_in = product;
         k_in   = k_ff + CountBits'(1);
         if (sts.last_step) begin
            fact_in = product;
            rsp_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         fact_ff <= '0;
      end else begin
         live_ff <= live_in;
         fact_ff <= fact_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      k_ff   <= k_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_read_data = rsp_ff;

endmodule

// ===== rtl/id_alive_factorial_regs.sv =====
// ----------------------------------------------------------------------------
// id_alive_factorial_regs
// memory-mapped device with identity, liveness and factorial registers
// ----------------------------------------------------------------------------
// a plain read or write is latched into the request registers, then answered in the
// exec state through the registered response; a factorial write of n in 2..33 also
//   runs the one-multiply-per-cycle loop in the datapath before it answers
// requests do not overlap: busy stays high until the previous one is answered
// reset (synchronous, active high) clears liveness and factorial words to zero
// responses are single-cycle strobes; the receiver cannot stall them
module id_alive_factorial_regs import idaf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // request side
   input  logic                start,
   output logic                busy,
   input  logic                req_operation,
   input  logic [AddrBits-1:0] req_address,
   input  logic [DataBits-1:0] req_write_data,
   // response side
   output logic                rsp_strobe,
   output logic [DataBits-1:0] rsp_read_data
);

   // commands from sequencer to datapath, status back
   cmd_type    cmd;
   status_type sts;

   // sequencer: idle -> exec -> (run for factorial loops) -> idle
   idaf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .sts        (sts)
   );

   // datapath holds the latched request, registers and the multiplier
   idaf_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_operation  (req_operation),
      .req_address    (req_address),
      .req_write_data (req_write_data),
      .rsp_read_data  (rsp_read_data)
   );

endmodule
